// File: sv/assert_macros.svh
// Assertion helpers shared by the RTL. Each macro expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/pff_pkg.sv
package pff_pkg;

	localparam int FRAME_BYTES = 9;
	localparam int POS_W = 4;

	localparam logic [POS_W-1:0] POS_END      = 4'd9;
	localparam logic [POS_W-1:0] POS_SUM_LAST = 4'd5;
	localparam logic [POS_W-1:0] POS_TAIL     = 4'd8;

	localparam logic [7:0] HEAD_MARK = 8'hAA;
	localparam logic [7:0] TAIL_MARK = 8'hBB;
	localparam logic [15:0] LIMIT_RESET = 16'd10;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_FINE_LIMIT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COARSE_LIMIT = 2'd1;

	localparam int STEP_W = 2;
	typedef logic [STEP_W-1:0] step_t;
	localparam step_t STEP_WAIT  = 2'd0;
	localparam step_t STEP_CHECK = 2'd1;
	localparam step_t STEP_MEAN  = 2'd2;
	localparam step_t STEP_OUT   = 2'd3;

	typedef enum logic [1:0] {
		COND_ALWAYS    = 2'd0,
		COND_FRAME_END = 2'd1,
		COND_MEAN_DONE = 2'd2,
		COND_OUT_FREE  = 2'd3
	} cond_t;

	// One control word of the sequencer program.
	typedef struct packed {
		logic  in_rdy;
		logic  chk;
		logic  mstep;
		logic  out_ld;
		cond_t cond;
		step_t tgt_t;
		step_t tgt_f;
	} ucode_t;

	typedef struct packed {
		logic frame_end;
		logic mean_done;
		logic out_free;
	} status_t;

	typedef struct packed {
		logic upd;
		logic mclr;
		logic mstep;
	} chan_ctl_t;

endpackage

// File: sv/pff_ifs.sv
interface pff_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       frame_start;
	modport source (output valid, rx_byte, frame_start, input ready);
	modport sink (input valid, rx_byte, frame_start, output ready);
endinterface

interface pff_result_if;
	logic        valid;
	logic        ready;
	logic        frame_ok;
	logic [15:0] fine_mean;
	logic [15:0] coarse_mean;
	logic [15:0] fine_alarms;
	logic [15:0] coarse_alarms;
	modport source (output valid, frame_ok, fine_mean, coarse_mean, fine_alarms,
		coarse_alarms, input ready);
	modport sink (input valid, frame_ok, fine_mean, coarse_mean, fine_alarms,
		coarse_alarms, output ready);
endinterface

interface pff_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [pff_pkg::CFG_IDX_W-1:0] index;
	logic [15:0]                   data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: sv/pff_seq.sv
module pff_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  pff_pkg::status_t st,
	output pff_pkg::ucode_t  ctl
);

	pff_pkg::step_t step_q;
	logic           take;

	function automatic pff_pkg::ucode_t rom(input pff_pkg::step_t s);
		pff_pkg::ucode_t w;
		w = '0;
		unique case (s)
			pff_pkg::STEP_WAIT: begin
				w.in_rdy = 1'b1;
				w.cond   = pff_pkg::COND_FRAME_END;
				w.tgt_t  = pff_pkg::STEP_CHECK;
				w.tgt_f  = pff_pkg::STEP_WAIT;
			end
			pff_pkg::STEP_CHECK: begin
				w.chk   = 1'b1;
				w.cond  = pff_pkg::COND_ALWAYS;
				w.tgt_t = pff_pkg::STEP_MEAN;
				w.tgt_f = pff_pkg::STEP_MEAN;
			end
			pff_pkg::STEP_MEAN: begin
				w.mstep = 1'b1;
				w.cond  = pff_pkg::COND_MEAN_DONE;
				w.tgt_t = pff_pkg::STEP_OUT;
				w.tgt_f = pff_pkg::STEP_MEAN;
			end
			pff_pkg::STEP_OUT: begin
				w.out_ld = 1'b1;
				w.cond   = pff_pkg::COND_OUT_FREE;
				w.tgt_t  = pff_pkg::STEP_WAIT;
				w.tgt_f  = pff_pkg::STEP_OUT;
			end
		endcase
		return w;
	endfunction

	assign ctl = rom(step_q);

	always_comb begin
		unique case (ctl.cond)
			pff_pkg::COND_ALWAYS:    take = 1'b1;
			pff_pkg::COND_FRAME_END: take = st.frame_end;
			pff_pkg::COND_MEAN_DONE: take = st.mean_done;
			pff_pkg::COND_OUT_FREE:  take = st.out_free;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= pff_pkg::STEP_WAIT;
		end else begin
			step_q <= take ? ctl.tgt_t : ctl.tgt_f;
		end
	end

endmodule

// File: sv/pff_chan.sv
module pff_chan #(
	parameter int WINDOW_LEN = 5
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pff_pkg::chan_ctl_t            ctl,
	input  logic [15:0]                   sample,
	input  logic [15:0]                   limit,
	input  logic [$clog2(WINDOW_LEN)-1:0] slot,
	input  logic [$clog2(WINDOW_LEN)-1:0] idx,
	output logic [15:0]                   mean,
	output logic [15:0]                   alarms
);

	logic [15:0] win_q [WINDOW_LEN];
	logic [15:0] prev_q;
	logic [15:0] count_q;
	logic [15:0] mean_q;
	logic [16:0] diff;
	logic [16:0] acc;
	logic        alarm;

	// A set top bit means the sample fell, which never counts as a rise.
	assign diff  = {1'b0, sample} - {1'b0, prev_q};
	assign alarm = !diff[16] && (diff[15:0] > limit);
	assign acc   = {1'b0, mean_q} + {1'b0, win_q[idx]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_LEN; i++) begin
				win_q[i] <= '0;
			end
			prev_q  <= '0;
			count_q <= '0;
			mean_q  <= '0;
		end else begin
			if (ctl.upd) begin
				win_q[slot] <= sample;
				prev_q      <= sample;
				if (alarm && count_q != 16'hFFFF) begin
					count_q <= count_q + 16'd1;
				end
			end
			if (ctl.mclr) begin
				mean_q <= '0;
			end else if (ctl.mstep) begin
				mean_q <= acc[16:1];
			end
		end
	end

	assign mean   = mean_q;
	assign alarms = count_q;

endmodule

// File: sv/particulate_frame_filter_top.sv
// A byte that does not end a frame is taken and leaves the sequencer in its wait step.
// The ninth byte of a frame ends it: the sequencer then runs its check step, one mean
// step per window entry and its output step, which loads the result word, and the next
// byte is taken once it is back in its wait step. A result word still waiting for the
// receiver holds the sequencer in its output step.
// Reset clears windows, previous samples, counts and position and sets both limits to 10.
`include "assert_macros.svh"

module particulate_frame_filter_top #(
	parameter int WINDOW_LEN = 5
) (
	input logic          clk,
	input logic          arst_n,
	pff_byte_if.sink     rx,
	pff_result_if.source res,
	pff_cfg_if.sink      cfg
);

	localparam int SLOT_W = $clog2(WINDOW_LEN);
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_LEN - 1);

	pff_pkg::ucode_t   ctl;
	pff_pkg::status_t  st;
	pff_pkg::chan_ctl_t cctl;

	logic [7:0]               bytes_q [pff_pkg::FRAME_BYTES];
	logic [pff_pkg::POS_W-1:0] pos_q;
	logic [pff_pkg::POS_W-1:0] pos_eff;
	logic [15:0]              sum_q;
	logic [15:0]              sum_eff;
	logic [15:0]              fine_lim_q;
	logic [15:0]              coarse_lim_q;
	logic [SLOT_W-1:0]        slot_q;
	logic [SLOT_W-1:0]        idx_q;
	logic                     accept;
	logic                     in_frame;
	logic                     ok_c;
	logic                     ok_q;
	logic                     out_valid_q;
	logic                     frame_ok_q;
	logic [15:0]              fine_mean_q;
	logic [15:0]              coarse_mean_q;
	logic [15:0]              fine_alarms_q;
	logic [15:0]              coarse_alarms_q;
	logic [15:0]              fine_mean;
	logic [15:0]              coarse_mean;
	logic [15:0]              fine_alarms;
	logic [15:0]              coarse_alarms;
	logic [15:0]              fine_sample;
	logic [15:0]              coarse_sample;

	pff_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.ctl    (ctl)
	);

	assign rx.ready = ctl.in_rdy;
	assign accept   = rx.valid && rx.ready;

	// A start flag restarts the frame before this word is placed.
	assign pos_eff  = rx.frame_start ? '0 : pos_q;
	assign sum_eff  = rx.frame_start ? '0 : sum_q;
	assign in_frame = pos_eff < pff_pkg::POS_END;

	always_ff @(posedge clk) begin
		if (accept && in_frame) begin
			bytes_q[pos_eff] <= rx.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			sum_q <= '0;
		end else if (accept) begin
			if (in_frame) begin
				pos_q <= pos_eff + 4'd1;
				if (pos_eff <= pff_pkg::POS_SUM_LAST || pos_eff == pff_pkg::POS_TAIL) begin
					sum_q <= sum_eff + {8'd0, rx.rx_byte};
				end else begin
					sum_q <= sum_eff;
				end
			end else begin
				pos_q <= pos_eff;
				sum_q <= sum_eff;
			end
		end
	end

	assign ok_c = (bytes_q[0] == pff_pkg::HEAD_MARK) && (bytes_q[8] == pff_pkg::TAIL_MARK) &&
		(sum_q == {bytes_q[6], bytes_q[7]});

	assign fine_sample   = {bytes_q[4], bytes_q[5]};
	assign coarse_sample = {bytes_q[2], bytes_q[3]};

	assign cctl.upd   = ctl.chk && ok_c;
	assign cctl.mclr  = ctl.chk;
	assign cctl.mstep = ctl.mstep;

	assign st.frame_end = accept && (pos_eff == pff_pkg::POS_TAIL);
	assign st.mean_done = idx_q == SLOT_LAST;
	assign st.out_free  = !out_valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			idx_q  <= '0;
			ok_q   <= 1'b0;
		end else begin
			if (cctl.upd) begin
				slot_q <= (slot_q == SLOT_LAST) ? '0 : slot_q + SLOT_W'(1);
			end
			if (ctl.chk) begin
				ok_q  <= ok_c;
				idx_q <= '0;
			end else if (ctl.mstep && idx_q != SLOT_LAST) begin
				idx_q <= idx_q + SLOT_W'(1);
			end
		end
	end

	pff_chan #(.WINDOW_LEN(WINDOW_LEN)) u_fine (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (cctl),
		.sample (fine_sample),
		.limit  (fine_lim_q),
		.slot   (slot_q),
		.idx    (idx_q),
		.mean   (fine_mean),
		.alarms (fine_alarms)
	);

	pff_chan #(.WINDOW_LEN(WINDOW_LEN)) u_coarse (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (cctl),
		.sample (coarse_sample),
		.limit  (coarse_lim_q),
		.slot   (slot_q),
		.idx    (idx_q),
		.mean   (coarse_mean),
		.alarms (coarse_alarms)
	);

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fine_lim_q   <= pff_pkg::LIMIT_RESET;
			coarse_lim_q <= pff_pkg::LIMIT_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				pff_pkg::REG_FINE_LIMIT:   fine_lim_q <= cfg.data;
				pff_pkg::REG_COARSE_LIMIT: coarse_lim_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_ld && st.out_free) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_ld && st.out_free) begin
			frame_ok_q      <= ok_q;
			fine_mean_q     <= fine_mean;
			coarse_mean_q   <= coarse_mean;
			fine_alarms_q   <= fine_alarms;
			coarse_alarms_q <= coarse_alarms;
		end
	end

	assign res.valid         = out_valid_q;
	assign res.frame_ok      = frame_ok_q;
	assign res.fine_mean     = fine_mean_q;
	assign res.coarse_mean   = coarse_mean_q;
	assign res.fine_alarms   = fine_alarms_q;
	assign res.coarse_alarms = coarse_alarms_q;

	`ASSERT_NEXT(a_slot_hold, !cctl.upd, $stable(slot_q), "window slot moved without a good frame")
	`ASSERT_IMPL(a_slot_range, 1'b1, slot_q <= SLOT_LAST, "window slot out of range")
	`ASSERT_IMPL(a_mean_done, ctl.out_ld, idx_q == SLOT_LAST, "result loaded before mean finished")

endmodule

// File: verif/tb_particulate_frame_filter_top.sv
module tb_particulate_frame_filter_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WIN = 5;
	localparam int CYCLE_LIMIT = 500000;
	localparam int PHASE_WORDS = 420;
	localparam int SETTLE_CYCLES = 2 * (WIN + 3) + 4;

	typedef struct packed {
		logic        frame_ok;
		logic [15:0] fine_mean;
		logic [15:0] coarse_mean;
		logic [15:0] fine_alarms;
		logic [15:0] coarse_alarms;
	} frame_report_t;

	typedef enum int {
		FR_GOOD,
		FR_BAD_HEAD,
		FR_BAD_TAIL,
		FR_BAD_SUM,
		FR_SHORT,
		FR_LONG,
		FR_NOISE
	} frame_kind_t;

	// Tracks the frame decoder and both sample filters, and holds the reports still owed.
	class frame_scoreboard;
		logic [15:0] fine_limit;
		logic [15:0] coarse_limit;
		logic [3:0] pos;
		logic [15:0] sum;
		logic [7:0] fbytes [pff_pkg::FRAME_BYTES];
		logic [15:0] fine_win [WIN];
		logic [15:0] coarse_win [WIN];
		int unsigned slot;
		logic [15:0] fine_prev;
		logic [15:0] coarse_prev;
		logic [15:0] fine_cnt;
		logic [15:0] coarse_cnt;
		frame_report_t owed [$];
		int errors;

		function new();
			fine_limit = pff_pkg::LIMIT_RESET;
			coarse_limit = pff_pkg::LIMIT_RESET;
			pos = '0;
			sum = '0;
			foreach (fbytes[i]) fbytes[i] = '0;
			foreach (fine_win[i]) fine_win[i] = '0;
			foreach (coarse_win[i]) coarse_win[i] = '0;
			slot = 0;
			fine_prev = '0;
			coarse_prev = '0;
			fine_cnt = '0;
			coarse_cnt = '0;
			errors = 0;
		endfunction

		function void set_limit(logic [pff_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
			if (idx == pff_pkg::REG_FINE_LIMIT) begin
				fine_limit = val;
			end else if (idx == pff_pkg::REG_COARSE_LIMIT) begin
				coarse_limit = val;
			end
		endfunction

		function logic [15:0] window_mean(input logic [15:0] w [WIN]);
			logic [16:0] m;
			m = '0;
			for (int i = 0; i < WIN; i++)
				m = (m + {1'b0, w[i]}) >> 1;
			return m[15:0];
		endfunction

		// The rise is a full signed difference; a fall never counts.
		function logic [15:0] next_count(logic [15:0] cnt, logic [15:0] prev,
				logic [15:0] sample, logic [15:0] limit);
			int rise;
			rise = int'({16'd0, sample}) - int'({16'd0, prev});
			if (rise > int'({16'd0, limit}) && cnt != 16'hFFFF)
				return cnt + 16'd1;
			return cnt;
		endfunction

		function void note_input(logic [7:0] b, logic s);
			logic ok;
			logic [15:0] fine;
			logic [15:0] coarse;
			frame_report_t rep;
			if (s) begin
				pos = '0;
				sum = '0;
			end
			if (pos >= pff_pkg::FRAME_BYTES)
				return;
			fbytes[pos] = b;
			if (pos <= pff_pkg::POS_SUM_LAST || pos == pff_pkg::POS_TAIL)
				sum = sum + {8'd0, b};
			pos = pos + 4'd1;
			if (pos < pff_pkg::FRAME_BYTES)
				return;
			ok = fbytes[0] == pff_pkg::HEAD_MARK && fbytes[8] == pff_pkg::TAIL_MARK &&
				sum == {fbytes[6], fbytes[7]};
			if (ok) begin
				fine = {fbytes[4], fbytes[5]};
				coarse = {fbytes[2], fbytes[3]};
				fine_cnt = next_count(fine_cnt, fine_prev, fine, fine_limit);
				coarse_cnt = next_count(coarse_cnt, coarse_prev, coarse, coarse_limit);
				fine_prev = fine;
				coarse_prev = coarse;
				fine_win[slot] = fine;
				coarse_win[slot] = coarse;
				slot = (slot + 1) % WIN;
			end
			rep.frame_ok = ok;
			rep.fine_mean = window_mean(fine_win);
			rep.coarse_mean = window_mean(coarse_win);
			rep.fine_alarms = fine_cnt;
			rep.coarse_alarms = coarse_cnt;
			owed.push_back(rep);
		endfunction

		function void compare_field(string name, logic [15:0] e, logic [15:0] a);
			if (e !== a) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
			end
		endfunction

		function void check(frame_report_t got);
			frame_report_t want;
			if (owed.size() == 0) begin
				errors++;
				$display("%0t: unexpected report word, actual %h", $time, got);
				return;
			end
			want = owed.pop_front();
			compare_field("frame_ok", {15'd0, want.frame_ok}, {15'd0, got.frame_ok});
			compare_field("fine_mean", want.fine_mean, got.fine_mean);
			compare_field("coarse_mean", want.coarse_mean, got.coarse_mean);
			compare_field("fine_alarms", want.fine_alarms, got.fine_alarms);
			compare_field("coarse_alarms", want.coarse_alarms, got.coarse_alarms);
		endfunction
	endclass

	logic clk;
	logic arst_n;

	pff_byte_if rx_if ();
	pff_result_if res_if ();
	pff_cfg_if cfg_if ();

	particulate_frame_filter_top #(
		.WINDOW_LEN(WIN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx_if),
		.res(res_if),
		.cfg(cfg_if)
	);

	frame_scoreboard sb = new();
	bit idle_on;
	int hold_order;
	int fed;

	always #5 clk = ~clk;

	task automatic send_word(input logic [7:0] b, input logic s);
		while (idle_on && $urandom_range(99) < 35) begin
			rx_if.valid <= 1'b0;
			@(posedge clk);
		end
		rx_if.valid <= 1'b1;
		rx_if.rx_byte <= b;
		rx_if.frame_start <= s;
		do @(posedge clk); while (!rx_if.ready);
		sb.note_input(b, s);
	endtask

	task automatic write_limit(input logic [pff_pkg::CFG_IDX_W-1:0] idx,
			input logic [15:0] val);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= val;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		sb.set_limit(idx, val);
	endtask

	// Waits until every owed report is in, then lets any trailing work finish.
	task automatic drain();
		rx_if.valid <= 1'b0;
		while (sb.owed.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_sample();
		unique case ($urandom_range(3))
			0: return 16'($urandom);
			1: return 16'($urandom_range(40));
			2: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
			default: return 16'($urandom_range(600));
		endcase
	endfunction

	function automatic logic [15:0] frame_sum(input logic [7:0] fr [pff_pkg::FRAME_BYTES]);
		logic [15:0] s;
		s = '0;
		for (int i = 0; i <= 5; i++)
			s = s + {8'd0, fr[i]};
		return s + {8'd0, fr[8]};
	endfunction

	task automatic send_frame(input frame_kind_t kind, input logic [15:0] fine,
			input logic [15:0] coarse);
		logic [7:0] fr [pff_pkg::FRAME_BYTES];
		logic [15:0] s;
		int n;
		fr[0] = pff_pkg::HEAD_MARK;
		fr[1] = 8'($urandom);
		fr[2] = coarse[15:8];
		fr[3] = coarse[7:0];
		fr[4] = fine[15:8];
		fr[5] = fine[7:0];
		fr[8] = pff_pkg::TAIL_MARK;
		if (kind == FR_BAD_HEAD)
			fr[0] = pff_pkg::HEAD_MARK ^ 8'($urandom_range(1, 255));
		if (kind == FR_BAD_TAIL)
			fr[8] = pff_pkg::TAIL_MARK ^ 8'($urandom_range(1, 255));
		s = frame_sum(fr);
		fr[6] = s[15:8];
		fr[7] = s[7:0];
		if (kind == FR_BAD_SUM)
			fr[6 + $urandom_range(1)] ^= 8'($urandom_range(1, 255));
		if (kind == FR_NOISE) begin
			n = $urandom_range(1, 12);
			repeat (n) send_word(8'($urandom), $urandom_range(3) == 0);
			fed += n;
			return;
		end
		n = (kind == FR_SHORT) ? $urandom_range(1, pff_pkg::FRAME_BYTES - 1) :
			pff_pkg::FRAME_BYTES;
		// The first word mostly carries the start flag; without it the decoder must
		// already sit at the frame head for the frame to line up.
		send_word(fr[0], $urandom_range(9) != 0);
		for (int i = 1; i < n; i++)
			send_word(fr[i], 1'b0);
		fed += n;
		if (kind == FR_LONG)
			repeat ($urandom_range(1, 3)) send_word(8'($urandom), 1'b0);
	endtask

	task automatic random_phase(input int words);
		int r;
		frame_kind_t kind;
		fed = 0;
		while (fed < words) begin
			r = $urandom_range(99);
			if (r < 70)
				kind = FR_GOOD;
			else if (r < 75)
				kind = FR_BAD_HEAD;
			else if (r < 80)
				kind = FR_BAD_TAIL;
			else if (r < 87)
				kind = FR_BAD_SUM;
			else if (r < 92)
				kind = FR_SHORT;
			else if (r < 96)
				kind = FR_LONG;
			else
				kind = FR_NOISE;
			send_frame(kind, pick_sample(), pick_sample());
		end
	endtask

	initial begin
		int n;
		n = 0;
		while (n < CYCLE_LIMIT) begin
			@(posedge clk);
			n++;
		end
		$display("tb_particulate_frame_filter_top: done, errors");
		$finish;
	end

	// Result side: checks every accepted word, stalls at random while idling is on and holds off when ordered.
	initial begin
		int hold_left;
		frame_report_t got;
		hold_left = 0;
		res_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (res_if.valid && res_if.ready) begin
				got.frame_ok = res_if.frame_ok;
				got.fine_mean = res_if.fine_mean;
				got.coarse_mean = res_if.coarse_mean;
				got.fine_alarms = res_if.fine_alarms;
				got.coarse_alarms = res_if.coarse_alarms;
				sb.check(got);
			end
			if (hold_order > 0) begin
				hold_left = hold_order;
				hold_order = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_if.ready <= 1'b0;
			end else if (idle_on) begin
				res_if.ready <= $urandom_range(99) >= 35;
			end else begin
				res_if.ready <= 1'b1;
			end
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		idle_on = 1'b1;
		hold_order = 0;
		fed = 0;
		rx_if.valid = 1'b0;
		rx_if.rx_byte = '0;
		rx_if.frame_start = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.index = pff_pkg::REG_FINE_LIMIT;
		cfg_if.data = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: full-scale samples, trailing bytes that must be ignored, a cut-off
		// frame, then a restart with zero samples.
		send_frame(FR_GOOD, 16'hFFFF, 16'hFFFF);
		send_word(8'h00, 1'b0);
		send_word(8'hFF, 1'b0);
		send_word(pff_pkg::HEAD_MARK, 1'b1);
		send_word(8'hFF, 1'b0);
		send_word(8'h00, 1'b0);
		send_frame(FR_GOOD, 16'h0000, 16'h0000);
		drain();

		write_limit(pff_pkg::REG_FINE_LIMIT, 16'h0000);
		write_limit(pff_pkg::REG_COARSE_LIMIT, 16'hFFFF);
		random_phase(PHASE_WORDS);
		drain();

		// A stretch with no idling on either side.
		idle_on = 1'b0;
		write_limit(pff_pkg::REG_FINE_LIMIT, 16'hFFFF);
		write_limit(pff_pkg::REG_COARSE_LIMIT, 16'h0000);
		random_phase(PHASE_WORDS);
		drain();
		idle_on = 1'b1;

		// The result side holds off long enough to back up the byte input.
		write_limit(pff_pkg::REG_FINE_LIMIT, 16'($urandom_range(600)));
		write_limit(pff_pkg::REG_COARSE_LIMIT, 16'($urandom));
		hold_order = 400;
		random_phase(PHASE_WORDS);
		drain();

		write_limit(pff_pkg::REG_FINE_LIMIT, pff_pkg::LIMIT_RESET);
		write_limit(pff_pkg::REG_COARSE_LIMIT, 16'($urandom_range(40)));
		random_phase(PHASE_WORDS);
		drain();

		if (sb.errors == 0) begin
			$display("tb_particulate_frame_filter_top: done, clean");
		end else begin
			$display("tb_particulate_frame_filter_top: done, errors");
		end
		$finish;
	end
endmodule

// File: filelist.f
+incdir+sv
sv/pff_pkg.sv
sv/pff_ifs.sv
sv/pff_seq.sv
sv/pff_chan.sv
sv/particulate_frame_filter_top.sv
verif/tb_particulate_frame_filter_top.sv
